FILE: rtl/coap_pkg.sv
// ----------------------------------------------------------------------------
// coap_pkg
// Shared types and constants of the CoAP message parser.
// ----------------------------------------------------------------------------
package coap_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERSION   = 1'b0,
		CFG_TOKEN_MAX = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_HDR   = 4'd0,
		PH_CODE  = 4'd1,
		PH_MID0  = 4'd2,
		PH_MID1  = 4'd3,
		PH_TOK   = 4'd4,
		PH_OPT   = 4'd5,
		PH_DEXT  = 4'd6,
		PH_LEXT  = 4'd7,
		PH_VAL   = 4'd8,
		PH_PAY   = 4'd9,
		PH_DRAIN = 4'd10
	} phase_t;

	typedef enum logic [3:0] {
		K_HEADER  = 4'd0,
		K_CODE    = 4'd1,
		K_MSGID   = 4'd2,
		K_TOKEN   = 4'd3,
		K_OPTHDR  = 4'd4,
		K_OPTEXT  = 4'd5,
		K_OPTVAL  = 4'd6,
		K_MARKER  = 4'd7,
		K_PAYLOAD = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		E_OK      = 3'd0,
		E_SHORT   = 3'd1,
		E_VERSION = 3'd2,
		E_TOKLEN  = 3'd3,
		E_TOKCUT  = 3'd4,
		E_DELTA   = 3'd5,
		E_LENGTH  = 3'd6,
		E_VALCUT  = 3'd7
	} err_t;

	// pre-decoded byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       marker;
		logic       hi_ext;
		logic       hi_rsv;
		logic       lo_rsv;
	} pre_t;

endpackage

FILE: rtl/coap_ifs.sv
// ----------------------------------------------------------------------------
// coap_ifs
// Channel interfaces: input bytes, parse results, configuration writes.
// ----------------------------------------------------------------------------
interface coap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface coap_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  byte_kind;
	logic [7:0]  byte_value;
	logic [15:0] option_number;
	logic [15:0] option_length;
	logic [15:0] message_id;
	logic [2:0]  err_status;
	logic        message_end;

	modport source (output valid, byte_kind, byte_value, option_number, option_length,
		message_id, err_status, message_end, input ready);
	modport sink   (input valid, byte_kind, byte_value, option_number, option_length,
		message_id, err_status, message_end, output ready);
endinterface

interface coap_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [coap_pkg::CFG_IDX_W-1:0] index;
	logic [coap_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/coap_message_parser.sv
// ----------------------------------------------------------------------------
// coap_message_parser
// CoAP message parser: labels each byte of a message with its role.
//
// byte_in carries one message byte per transaction with last_byte on the
// final byte. result_out gives one transaction per input byte, in order,
// with the byte kind, running option number, option length, message id,
// sticky error code and message_end. cfg writes expected_version (index 0)
// and max_token_length (index 1); it is always ready. cfg is to be
// written only while the parser is idle; the block does not enforce this.
// An input byte passes through the queue and then the result register before
// its result is valid. One byte is taken per cycle while the queue is not
// full: the front stage pre-decodes into a four-entry queue and the parser
// state machine retires one entry per cycle into the result register while
// result_out is not stalled. When result_out stalls, the queue fills and
// byte_in.ready drops once it is full. Reset clears all message state and
// sets the registers to version 1 and token length limit 8.
// ----------------------------------------------------------------------------
module coap_message_parser (
	input  logic          clk,
	input  logic          arst_n,
	coap_byte_if.sink     byte_in,
	coap_result_if.source result_out,
	coap_cfg_if.sink      cfg
);
	import coap_pkg::*;

	logic q_full;
	logic q_push;
	pre_t q_wdata;
	logic q_pop;
	logic q_nonempty;
	pre_t q_rdata;

	coap_front u_front (
		.byte_in (byte_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	coap_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	coap_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.cfg        (cfg),
		.result_out (result_out)
	);

endmodule

FILE: rtl/coap_front.sv
// ----------------------------------------------------------------------------
// coap_front
// Accepts input bytes and pre-decodes nibble classes into the queue.
// ----------------------------------------------------------------------------
module coap_front (
	coap_byte_if.sink       byte_in,
	input  logic            q_full,
	output logic            q_push,
	output coap_pkg::pre_t  q_wdata
);
	import coap_pkg::*;

	logic [3:0] hi;
	logic [3:0] lo;

	assign hi = byte_in.data_byte[7:4];
	assign lo = byte_in.data_byte[3:0];

	assign byte_in.ready = !q_full;
	assign q_push        = byte_in.valid && !q_full;

	always_comb begin
		q_wdata.data   = byte_in.data_byte;
		q_wdata.last   = byte_in.last_byte;
		q_wdata.marker = (byte_in.data_byte == 8'hFF);
		q_wdata.hi_ext = (hi inside {4'd13, 4'd14});
		q_wdata.hi_rsv = (hi == 4'd15);
		q_wdata.lo_rsv = (lo == 4'd15);
	end

endmodule

FILE: rtl/coap_fifo.sv
// ----------------------------------------------------------------------------
// coap_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module coap_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  coap_pkg::pre_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output coap_pkg::pre_t rdata
);
	import coap_pkg::*;

	pre_t           mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QCW-1:0] count_q;

	assign full     = (count_q == QCW'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH)) else $error("queue count over depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("push lost");
`endif

endmodule

FILE: rtl/coap_back.sv
// ----------------------------------------------------------------------------
// coap_back
// Parser state machine and result register; holds the configuration registers.
// ----------------------------------------------------------------------------
module coap_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nonempty,
	input  coap_pkg::pre_t q_rdata,
	output logic           q_pop,
	coap_cfg_if.sink       cfg,
	coap_result_if.source  result_out
);
	import coap_pkg::*;

	function automatic logic [8:0] ext_bias(input logic [3:0] nib);
		return (nib == 4'd13) ? 9'd13 : 9'd269;
	endfunction

	// configuration
	logic [1:0] ver_q;
	logic [3:0] tmax_q;

	// message state
	phase_t      ph_q, ph_n;
	logic [1:0]  hc_q, hc_n;
	logic [3:0]  tok_q, tok_n;
	logic [3:0]  dn_q, dn_n;
	logic [3:0]  ln_q, ln_n;
	logic [15:0] ext_q, ext_n;
	logic [15:0] run_q, run_n;
	logic [16:0] vr_q, vr_n;
	logic [15:0] id_q, id_n;
	err_t        err_q, err_n;

	// result register
	logic        ovalid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic [15:0] onum_q;
	logic [15:0] olen_q;
	logic [15:0] oid_q;
	err_t        oerr_q;
	logic        oend_q;

	logic [7:0]  b;
	logic [15:0] ext_shift;
	logic        do_begin;
	logic [3:0]  bnib;
	logic        do_set;
	logic [16:0] slen;
	logic        rs;
	err_t        rcode;
	err_t        lcode;
	kind_t       kind;
	logic [15:0] olen;

	assign b         = q_rdata.data;
	assign ext_shift = {ext_q[7:0], b};
	assign q_pop     = q_nonempty && (!ovalid_q || result_out.ready);
	assign cfg.ready = 1'b1;

	always_comb begin
		ph_n  = ph_q;
		hc_n  = hc_q;
		tok_n = tok_q;
		dn_n  = dn_q;
		ln_n  = ln_q;
		ext_n = ext_q;
		run_n = run_q;
		vr_n  = vr_q;
		id_n  = id_q;
		err_n = err_q;
		do_begin = 1'b0;
		bnib     = ln_q;
		do_set   = 1'b0;
		slen     = '0;
		rs       = 1'b0;
		rcode    = E_OK;
		lcode    = E_OK;
		case (ph_q)
			PH_HDR: begin
				tok_n = b[3:0];
				ph_n  = PH_CODE;
				if (b[7:6] != ver_q) begin
					rs = 1'b1; rcode = E_VERSION;
				end else if (b[3:0] > tmax_q) begin
					rs = 1'b1; rcode = E_TOKLEN;
				end
			end
			PH_CODE: ph_n = PH_MID0;
			PH_MID0: begin
				id_n = {b, 8'h00};
				ph_n = PH_MID1;
			end
			PH_MID1: begin
				id_n = {id_q[15:8], b};
				ph_n = (tok_q != '0) ? PH_TOK : PH_OPT;
			end
			PH_TOK: begin
				tok_n = tok_q - 1'b1;
				if (tok_q == 4'd1) ph_n = PH_OPT;
			end
			PH_OPT: begin
				if (q_rdata.marker) begin
					ph_n = PH_PAY;
				end else begin
					dn_n  = b[7:4];
					ln_n  = b[3:0];
					ext_n = '0;
					if (q_rdata.hi_rsv) begin
						rs = 1'b1; rcode = E_DELTA;
					end else if (q_rdata.lo_rsv) begin
						rs = 1'b1; rcode = E_LENGTH;
					end else if (q_rdata.hi_ext) begin
						hc_n = b[5:4];
						ph_n = PH_DEXT;
					end else begin
						run_n    = run_q + {12'd0, b[7:4]};
						do_begin = 1'b1;
						bnib     = b[3:0];
					end
				end
			end
			PH_DEXT: begin
				ext_n = ext_shift;
				hc_n  = hc_q - 1'b1;
				if (hc_q == 2'd1) begin
					run_n    = run_q + ext_shift + {7'd0, ext_bias(dn_q)};
					ext_n    = '0;
					do_begin = 1'b1;
				end
			end
			PH_LEXT: begin
				ext_n = ext_shift;
				hc_n  = hc_q - 1'b1;
				if (hc_q == 2'd1) begin
					do_set = 1'b1;
					slen   = {1'b0, ext_shift} + {8'd0, ext_bias(ln_q)};
				end
			end
			PH_VAL: begin
				vr_n = vr_q - 1'b1;
				if (vr_q == 17'd1) ph_n = PH_OPT;
			end
			default: ;
		endcase

		if (do_begin) begin
			if (bnib inside {4'd13, 4'd14}) begin
				hc_n  = bnib[1:0];
				ext_n = '0;
				ph_n  = PH_LEXT;
			end else begin
				do_set = 1'b1;
				slen   = {13'd0, bnib};
			end
		end
		if (do_set) begin
			vr_n  = slen;
			ext_n = slen[16] ? 16'hFFFF : slen[15:0];
			ph_n  = (slen != '0) ? PH_VAL : PH_OPT;
		end
		if (rs) begin
			if (err_q == E_OK) err_n = rcode;
			ph_n = PH_DRAIN;
		end

		if (q_rdata.last) begin
			case (ph_n)
				PH_CODE, PH_MID0, PH_MID1: lcode = E_SHORT;
				PH_TOK:                    lcode = E_TOKCUT;
				PH_DEXT:                   lcode = E_DELTA;
				PH_LEXT:                   lcode = E_LENGTH;
				PH_VAL:                    lcode = E_VALCUT;
				default:                   lcode = E_OK;
			endcase
		end
		if (lcode != E_OK) begin
			if (err_n == E_OK) err_n = lcode;
			ph_n = PH_DRAIN;
		end
	end

	always_comb begin
		case (ph_q)
			PH_HDR:           kind = K_HEADER;
			PH_CODE:          kind = K_CODE;
			PH_MID0, PH_MID1: kind = K_MSGID;
			PH_TOK:           kind = K_TOKEN;
			PH_OPT:           kind = q_rdata.marker ? K_MARKER : K_OPTHDR;
			PH_DEXT, PH_LEXT: kind = K_OPTEXT;
			PH_VAL:           kind = K_OPTVAL;
			default:          kind = K_PAYLOAD;
		endcase
		olen = (ph_n == PH_DEXT || ph_n == PH_LEXT) ? 16'd0 : ext_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q  <= 2'd1;
			tmax_q <= 4'd8;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_VERSION:   ver_q  <= cfg.data[1:0];
				CFG_TOKEN_MAX: tmax_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HDR;
			hc_q  <= '0;
			tok_q <= '0;
			dn_q  <= '0;
			ln_q  <= '0;
			ext_q <= '0;
			run_q <= '0;
			vr_q  <= '0;
			id_q  <= '0;
			err_q <= E_OK;
		end else if (q_pop) begin
			if (q_rdata.last) begin
				ph_q  <= PH_HDR;
				hc_q  <= '0;
				tok_q <= '0;
				dn_q  <= '0;
				ln_q  <= '0;
				ext_q <= '0;
				run_q <= '0;
				vr_q  <= '0;
				id_q  <= '0;
				err_q <= E_OK;
			end else begin
				ph_q  <= ph_n;
				hc_q  <= hc_n;
				tok_q <= tok_n;
				dn_q  <= dn_n;
				ln_q  <= ln_n;
				ext_q <= ext_n;
				run_q <= run_n;
				vr_q  <= vr_n;
				id_q  <= id_n;
				err_q <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (q_pop) begin
			ovalid_q <= 1'b1;
		end else if (result_out.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= kind;
			byte_q <= b;
			onum_q <= run_n;
			olen_q <= olen;
			oid_q  <= id_n;
			oerr_q <= err_n;
			oend_q <= q_rdata.last;
		end
	end

	assign result_out.valid         = ovalid_q;
	assign result_out.byte_kind     = kind_q;
	assign result_out.byte_value    = byte_q;
	assign result_out.option_number = onum_q;
	assign result_out.option_length = olen_q;
	assign result_out.message_id    = oid_q;
	assign result_out.err_status    = oerr_q;
	assign result_out.message_end   = oend_q;

`ifndef ASSERT_OFF
	a_drain_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DRAIN) |-> (err_q != E_OK)) else $error("drain without error");
	a_value_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_VAL) |-> (vr_q != '0)) else $error("value phase with zero count");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_rdata.last) |=> (ph_q == PH_HDR && err_q == E_OK && run_q == '0))
		else $error("message state not cleared");
`endif

endmodule
